// ===== rtl/core/rpqm_pkg.sv =====
// Shared types and constants for the rate PID quad motor mixer.
package rpqm_pkg;

    // Field widths
    localparam int RATE_W  = 16;
    localparam int STICK_W = 12;
    localparam int GAIN_W  = 16;
    localparam int MOTOR_W = 12;
    localparam int SUM_W   = 32;
    localparam int SP_W    = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Stick deadband edges in microseconds
    localparam logic [STICK_W-1:0] DEAD_HIGH = 12'd1508;
    localparam logic [STICK_W-1:0] DEAD_LOW  = 12'd1492;

    // Divide by three as multiply by 2731 / 2^13 (exact for 12-bit magnitudes)
    localparam logic [11:0] DIV3_MUL   = 12'd2731;
    localparam int          DIV3_SHIFT = 13;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PR_P_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PR_I_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PR_D_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_YAW_P_GAIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_YAW_I_GAIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_YAW_D_GAIN = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MOTOR_FLOOR = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MOTOR_CEIL  = 3'd7;

    // Configuration reset values
    localparam logic [GAIN_W-1:0]  PR_P_GAIN_INIT  = 16'd768;
    localparam logic [GAIN_W-1:0]  PR_I_GAIN_INIT  = 16'd0;
    localparam logic [GAIN_W-1:0]  PR_D_GAIN_INIT  = 16'd0;
    localparam logic [GAIN_W-1:0]  YAW_P_GAIN_INIT = 16'd256;
    localparam logic [GAIN_W-1:0]  YAW_I_GAIN_INIT = 16'd0;
    localparam logic [GAIN_W-1:0]  YAW_D_GAIN_INIT = 16'd0;
    localparam logic [MOTOR_W-1:0] MOTOR_FLOOR_INIT = 12'd1100;
    localparam logic [MOTOR_W-1:0] MOTOR_CEIL_INIT  = 12'd1800;

    // PID gains for one axis
    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd;
    } gains_t;

    // Pipeline load enables and the integrator update strobe
    typedef struct packed {
        logic ld_err;
        logic ld_sum;
        logic ld_prod;
        logic ld_axis;
        logic upd;
    } pipe_ctl_t;

    // Rate setpoint in whole deg/s: zero in the deadband, (stick - edge) / 3 toward zero
    function automatic logic signed [SP_W-1:0] stick_setpoint(input logic [STICK_W-1:0] stick);
        logic [STICK_W-1:0]   mag;
        logic [2*STICK_W-1:0] prod;
        logic [SP_W-1:0]      quo;
        mag = '0;
        if (stick > DEAD_HIGH)
        begin
            mag = stick - DEAD_HIGH;
        end
        else if (stick < DEAD_LOW)
        begin
            mag = DEAD_LOW - stick;
        end
        prod = mag * DIV3_MUL;
        quo  = prod[DIV3_SHIFT +: SP_W];
        if (stick < DEAD_LOW)
        begin
            return -$signed(quo);
        end
        return $signed(quo);
    endfunction

endpackage

// ===== rtl/core/rpqm_axis.sv =====
// One PID axis: error, saturating integrator, gain products and axis sum.
module rpqm_axis #(
    parameter int RATE_FRAC_BITS = 4,
    parameter int ERR_W          = 18,
    parameter int AX_W           = 51
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rpqm_pkg::pipe_ctl_t               ctl,
    input  logic signed [rpqm_pkg::RATE_W-1:0] rate,
    input  logic [rpqm_pkg::STICK_W-1:0]      stick,
    input  logic                              clear,
    input  rpqm_pkg::gains_t                  gains,
    output logic signed [AX_W-1:0]            axis_out
);
    import rpqm_pkg::*;

    localparam int DIFF_W = ERR_W + 1;
    localparam int PT_W   = ERR_W + GAIN_W + 1;
    localparam int IT_W   = SUM_W + GAIN_W + 1;
    localparam int DT_W   = DIFF_W + GAIN_W + 1;

    logic signed [ERR_W-1:0]  rate_x;
    logic signed [ERR_W-1:0]  sp_x;
    logic signed [ERR_W-1:0]  err1_next;
    logic signed [ERR_W-1:0]  err1_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [ERR_W-1:0]  prev_reg;
    logic signed [SUM_W-1:0]  base_sum;
    logic signed [ERR_W-1:0]  base_prev;
    logic signed [SUM_W:0]    sum_wide;
    logic signed [SUM_W-1:0]  sum_next;
    logic signed [DIFF_W-1:0] diff_next;
    logic signed [SUM_W-1:0]  sum2_reg;
    logic signed [ERR_W-1:0]  err2_reg;
    logic signed [DIFF_W-1:0] diff2_reg;
    logic signed [PT_W-1:0]   pt_next;
    logic signed [IT_W-1:0]   it_next;
    logic signed [DT_W-1:0]   dt_next;
    logic signed [PT_W-1:0]   pt_reg;
    logic signed [IT_W-1:0]   it_reg;
    logic signed [DT_W-1:0]   dt_reg;
    logic signed [AX_W-1:0]   axis_next;
    logic signed [AX_W-1:0]   axis_reg;

    // Error = -rate - setpoint scaled to rate units
    assign rate_x    = ERR_W'(rate);
    assign sp_x      = ERR_W'(stick_setpoint(stick)) <<< RATE_FRAC_BITS;
    assign err1_next = -rate_x - sp_x;

    always_ff @(posedge clk)
    begin
        if (ctl.ld_err)
        begin
            err1_reg <= err1_next;
        end
    end

    // Integrate with saturation at the 32-bit limits; clear zeroes the state first
    assign base_sum  = clear ? '0 : sum_reg;
    assign base_prev = clear ? '0 : prev_reg;
    assign sum_wide  = (SUM_W + 1)'(base_sum) + (SUM_W + 1)'(err1_reg);
    assign diff_next = DIFF_W'(err1_reg) - DIFF_W'(base_prev);

    always_comb
    begin
        sum_next = sum_wide[SUM_W-1:0];
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
        begin
            sum_next = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
    end

    // Hold integrator and last error; advance only as an item passes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            prev_reg <= '0;
        end
        else if (ctl.upd)
        begin
            sum_reg  <= sum_next;
            prev_reg <= err1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld_sum)
        begin
            sum2_reg  <= sum_next;
            err2_reg  <= err1_reg;
            diff2_reg <= diff_next;
        end
    end

    // Gain products, one multiplier per term
    assign pt_next = err2_reg * $signed({1'b0, gains.kp});
    assign it_next = sum2_reg * $signed({1'b0, gains.ki});
    assign dt_next = diff2_reg * $signed({1'b0, gains.kd});

    always_ff @(posedge clk)
    begin
        if (ctl.ld_prod)
        begin
            pt_reg <= pt_next;
            it_reg <= it_next;
            dt_reg <= dt_next;
        end
    end

    // Axis output
    assign axis_next = AX_W'(pt_reg) + AX_W'(it_reg) + AX_W'(dt_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.ld_axis)
        begin
            axis_reg <= axis_next;
        end
    end

    assign axis_out = axis_reg;

endmodule

// ===== rtl/core/rate_pid_quad_motor_mixer_unit.sv =====
// Top level: three-axis rate PID with quad X mixer and motor clamp.
// Stages: input, error, sum, product, axis and output registers lie between an input transfer and m_axis.
// Throughput: one item per cycle; the integrator closes its loop at the sum stage,
// and every stage stalls only when the one after it is full.
// Reset: rst_n clears all stage valids, integrators and last errors, and loads
// the gain and motor limit registers with their defaults.
module rate_pid_quad_motor_mixer_unit #(
    parameter int GAIN_FRAC_BITS = 8,
    parameter int RATE_FRAC_BITS = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // pitch_rate, roll_rate, yaw_rate, pitch_stick, roll_stick, yaw_stick, throttle_stick
    input  logic [95:0]                          s_axis_tdata,
    // clear_integrators
    input  logic                                 s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // motor_front_a, motor_front_b, motor_rear_b, motor_rear_a
    output logic [47:0]                          m_axis_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rpqm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rpqm_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import rpqm_pkg::*;

    localparam int FRAC_BITS = GAIN_FRAC_BITS + RATE_FRAC_BITS;
    localparam int ERR_W     = (RATE_FRAC_BITS + 12 > 18) ? RATE_FRAC_BITS + 12 : 18;
    localparam int AX_W      = SUM_W + GAIN_W + 3;
    localparam int MIX_W     = AX_W + 3;

    // Configuration registers
    logic [GAIN_W-1:0]  pr_kp_reg, pr_ki_reg, pr_kd_reg;
    logic [GAIN_W-1:0]  yaw_kp_reg, yaw_ki_reg, yaw_kd_reg;
    logic [MOTOR_W-1:0] floor_reg, ceil_reg;

    // Stage valids
    logic in_vld_reg, err_vld_reg, sum_vld_reg, prod_vld_reg, axis_vld_reg, out_vld_reg;
    logic in_rdy, err_rdy, sum_rdy, prod_rdy, axis_rdy, out_rdy;

    // Input stage payload
    logic signed [RATE_W-1:0] pitch_rate_reg, roll_rate_reg, yaw_rate_reg;
    logic [STICK_W-1:0]       pitch_stick_reg, roll_stick_reg, yaw_stick_reg;
    logic [STICK_W-1:0]       thr0_reg, thr1_reg, thr2_reg, thr3_reg, thr4_reg;
    logic                     clr0_reg, clr1_reg;

    pipe_ctl_t ctl;
    gains_t    pr_gains, yaw_gains;

    logic signed [AX_W-1:0]  pitch_ax, roll_ax, yaw_ax;
    logic signed [MIX_W-1:0] thr_x, p_x, r_x, y_x;
    logic [MOTOR_W-1:0]      front_a_next, front_b_next, rear_b_next, rear_a_next;
    logic [MOTOR_W-1:0]      front_a_reg, front_b_reg, rear_b_reg, rear_a_reg;

    // Write configuration; the port never stalls
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pr_kp_reg  <= PR_P_GAIN_INIT;
            pr_ki_reg  <= PR_I_GAIN_INIT;
            pr_kd_reg  <= PR_D_GAIN_INIT;
            yaw_kp_reg <= YAW_P_GAIN_INIT;
            yaw_ki_reg <= YAW_I_GAIN_INIT;
            yaw_kd_reg <= YAW_D_GAIN_INIT;
            floor_reg  <= MOTOR_FLOOR_INIT;
            ceil_reg   <= MOTOR_CEIL_INIT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PR_P_GAIN:   pr_kp_reg  <= cfg_data;
                REG_PR_I_GAIN:   pr_ki_reg  <= cfg_data;
                REG_PR_D_GAIN:   pr_kd_reg  <= cfg_data;
                REG_YAW_P_GAIN:  yaw_kp_reg <= cfg_data;
                REG_YAW_I_GAIN:  yaw_ki_reg <= cfg_data;
                REG_YAW_D_GAIN:  yaw_kd_reg <= cfg_data;
                REG_MOTOR_FLOOR: floor_reg  <= cfg_data[MOTOR_W-1:0];
                REG_MOTOR_CEIL:  ceil_reg   <= cfg_data[MOTOR_W-1:0];
                default:         floor_reg  <= floor_reg;
            endcase
        end
    end

    // A stage takes a new item when it is empty or its item moves on
    assign out_rdy  = !out_vld_reg  || m_axis_tready;
    assign axis_rdy = !axis_vld_reg || out_rdy;
    assign prod_rdy = !prod_vld_reg || axis_rdy;
    assign sum_rdy  = !sum_vld_reg  || prod_rdy;
    assign err_rdy  = !err_vld_reg  || sum_rdy;
    assign in_rdy   = !in_vld_reg   || err_rdy;

    assign s_axis_tready = in_rdy;

    assign ctl.ld_err  = err_rdy;
    assign ctl.ld_sum  = sum_rdy;
    assign ctl.ld_prod = prod_rdy;
    assign ctl.ld_axis = axis_rdy;
    assign ctl.upd     = err_vld_reg && sum_rdy;

    // Advance valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg   <= 1'b0;
            err_vld_reg  <= 1'b0;
            sum_vld_reg  <= 1'b0;
            prod_vld_reg <= 1'b0;
            axis_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            if (in_rdy)   in_vld_reg   <= s_axis_tvalid;
            if (err_rdy)  err_vld_reg  <= in_vld_reg;
            if (sum_rdy)  sum_vld_reg  <= err_vld_reg;
            if (prod_rdy) prod_vld_reg <= sum_vld_reg;
            if (axis_rdy) axis_vld_reg <= prod_vld_reg;
            if (out_rdy)  out_vld_reg  <= axis_vld_reg;
        end
    end

    // Capture the input transfer and carry throttle and clear alongside
    always_ff @(posedge clk)
    begin
        if (in_rdy)
        begin
            pitch_rate_reg  <= $signed(s_axis_tdata[15:0]);
            roll_rate_reg   <= $signed(s_axis_tdata[31:16]);
            yaw_rate_reg    <= $signed(s_axis_tdata[47:32]);
            pitch_stick_reg <= s_axis_tdata[59:48];
            roll_stick_reg  <= s_axis_tdata[71:60];
            yaw_stick_reg   <= s_axis_tdata[83:72];
            thr0_reg        <= s_axis_tdata[95:84];
            clr0_reg        <= s_axis_tuser;
        end
        if (err_rdy)
        begin
            thr1_reg <= thr0_reg;
            clr1_reg <= clr0_reg;
        end
        if (sum_rdy)
        begin
            thr2_reg <= thr1_reg;
        end
        if (prod_rdy)
        begin
            thr3_reg <= thr2_reg;
        end
        if (axis_rdy)
        begin
            thr4_reg <= thr3_reg;
        end
    end

    assign pr_gains  = '{kp: pr_kp_reg,  ki: pr_ki_reg,  kd: pr_kd_reg};
    assign yaw_gains = '{kp: yaw_kp_reg, ki: yaw_ki_reg, kd: yaw_kd_reg};

    rpqm_axis #(
        .RATE_FRAC_BITS (RATE_FRAC_BITS),
        .ERR_W          (ERR_W),
        .AX_W           (AX_W)
    ) u_pitch (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .rate     (pitch_rate_reg),
        .stick    (pitch_stick_reg),
        .clear    (clr1_reg),
        .gains    (pr_gains),
        .axis_out (pitch_ax)
    );

    rpqm_axis #(
        .RATE_FRAC_BITS (RATE_FRAC_BITS),
        .ERR_W          (ERR_W),
        .AX_W           (AX_W)
    ) u_roll (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .rate     (roll_rate_reg),
        .stick    (roll_stick_reg),
        .clear    (clr1_reg),
        .gains    (pr_gains),
        .axis_out (roll_ax)
    );

    rpqm_axis #(
        .RATE_FRAC_BITS (RATE_FRAC_BITS),
        .ERR_W          (ERR_W),
        .AX_W           (AX_W)
    ) u_yaw (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .rate     (yaw_rate_reg),
        .stick    (yaw_stick_reg),
        .clear    (clr1_reg),
        .gains    (yaw_gains),
        .axis_out (yaw_ax)
    );

    // Truncate a mixed sum to microseconds, floor negatives at zero, then clamp
    function automatic logic [MOTOR_W-1:0] motor_cmd(input logic signed [MIX_W-1:0] total,
                                                     input logic [MOTOR_W-1:0] lo,
                                                     input logic [MOTOR_W-1:0] hi);
        logic [MIX_W-1:0] v;
        v = total[MIX_W-1] ? '0 : MIX_W'(total >>> FRAC_BITS);
        if (v < MIX_W'(lo))
        begin
            return lo;
        end
        else if (v > MIX_W'(hi))
        begin
            return hi;
        end
        return v[MOTOR_W-1:0];
    endfunction

    // Mix the axes with throttle in the X layout
    assign thr_x = $signed(MIX_W'(thr4_reg)) <<< FRAC_BITS;
    assign p_x   = MIX_W'(pitch_ax);
    assign r_x   = MIX_W'(roll_ax);
    assign y_x   = MIX_W'(yaw_ax);

    assign front_a_next = motor_cmd(thr_x - p_x + r_x - y_x, floor_reg, ceil_reg);
    assign front_b_next = motor_cmd(thr_x + p_x + r_x + y_x, floor_reg, ceil_reg);
    assign rear_b_next  = motor_cmd(thr_x + p_x - r_x - y_x, floor_reg, ceil_reg);
    assign rear_a_next  = motor_cmd(thr_x - p_x - r_x + y_x, floor_reg, ceil_reg);

    always_ff @(posedge clk)
    begin
        if (out_rdy)
        begin
            front_a_reg <= front_a_next;
            front_b_reg <= front_b_next;
            rear_b_reg  <= rear_b_next;
            rear_a_reg  <= rear_a_next;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {rear_a_reg, rear_b_reg, front_b_reg, front_a_reg};

    // Ready drops only while the input stage holds an item
    assert property (@(posedge clk) disable iff (!rst_n) !s_axis_tready |-> in_vld_reg)
        else $error("input stall with empty input stage");

    // An input transfer always lands in the input stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> in_vld_reg)
        else $error("accepted item lost at input stage");

    // Integrator state moves exactly with an item entering the sum stage
    assert property (@(posedge clk) disable iff (!rst_n) ctl.upd |=> sum_vld_reg)
        else $error("integrator updated without an item");

endmodule
